>>> rtl/core/ttcw_pkg.sv
package ttcw_pkg;

	// Field widths of the transaction ports.
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned ROW_FIELD_W = 5;
	localparam int unsigned COL_FIELD_W = 7;

	// Character codes with a special meaning on the put path, and the blank used to clear cells.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// Transaction kinds selected by the mode field.
	localparam logic MODE_PUT  = 1'b0;
	localparam logic MODE_READ = 1'b1;

endpackage

>>> rtl/core/ttcw_ram.sv
module ttcw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/ttcw_addr_unit.sv
module ttcw_addr_unit #(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25,
	localparam int unsigned RW = $clog2(ROWS),
	localparam int unsigned CW = $clog2(COLUMNS),
	localparam int unsigned AW = $clog2(COLUMNS * ROWS)
) (
	input  logic          clk,
	input  logic [RW-1:0] top_row,
	input  logic [RW-1:0] vrow,
	input  logic [CW-1:0] col,
	output logic [AW-1:0] addr
);

	// Visible row plus the rotating top pointer, wrapped once (the sum stays below twice ROWS).
	logic [RW:0]   row_sum;
	logic [RW-1:0] phys_row;
	logic [AW-1:0] addr_q;

	always_comb begin
		row_sum = {1'b0, top_row} + {1'b0, vrow};
		if (32'(row_sum) >= ROWS) begin
			phys_row = RW'(32'(row_sum) - ROWS);
		end else begin
			phys_row = row_sum[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= AW'(AW'(phys_row) * AW'(COLUMNS)) + AW'(col);
	end

	assign addr = addr_q;

endmodule

>>> rtl/core/text_terminal_cell_writer.sv
// Character terminal for a COLUMNS x ROWS text screen. Each input transaction either puts one
// character at the cursor (mode 0) or reads one visible cell (mode 1), and each gives exactly one
// output transaction carrying the read character, the cursor position after the transaction and
// a scroll flag. Newline moves to column 0 of the next row, backspace moves left without erasing,
// and any other byte is stored and advances the cursor with wrap. Scrolling advances a rotating
// top-row pointer and blanks the old top row, so no text is copied. All cell addresses but those
// of the reset sweep come from one shared address unit (row wrap plus row-times-columns multiply,
// one registered result per cycle) feeding a single-port cell RAM with registered read, under a
// small sequencer that handles one transaction at a time. A visible read steps through address,
// memory and data states, a stored character through address, write and cursor states, a newline
// or a backspace only through the cursor state, and an off-screen read goes straight to done; a
// put that scrolls then makes one write per blanked cell through the RAM's only write port. After
// reset the block clears all COLUMNS * ROWS cells of the RAM to spaces, one cell per cycle, and
// holds in_ready low until that sweep ends. A finished result sits in an output register, so the
// next transaction is accepted while it still waits to be taken.
module text_terminal_cell_writer
	import ttcw_pkg::*;
#(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   mode,
	input  logic [CHAR_W-1:0]      char_code,
	input  logic [ROW_FIELD_W-1:0] read_row,
	input  logic [COL_FIELD_W-1:0] read_col,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAR_W-1:0]      read_char,
	output logic [COL_FIELD_W-1:0] cursor_col,
	output logic [ROW_FIELD_W-1:0] cursor_row,
	output logic                   scrolled
);

	localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
	localparam int unsigned RW = $clog2(ROWS);
	localparam int unsigned CW = $clog2(COLUMNS);
	localparam int unsigned AW = $clog2(CELL_COUNT);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RADDR,
		ST_RMEM,
		ST_RDATA,
		ST_WADDR,
		ST_WMEM,
		ST_CURSOR,
		ST_CLEAR,
		ST_CLRTAIL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Latched transaction and architectural state.
	logic                   mode_q;
	logic [CHAR_W-1:0]      char_q;
	logic [ROW_FIELD_W-1:0] rrow_q;
	logic [COL_FIELD_W-1:0] rcol_q;
	logic [RW-1:0]          top_q;
	logic [CW-1:0]          cur_col_q;
	logic [RW-1:0]          cur_row_q;
	logic [CHAR_W-1:0]      rchar_q;
	logic                   scroll_q;

	// Sweep counters and the delayed write strobe of the blanking loop.
	logic [AW-1:0]          init_cnt_q;
	logic [CW-1:0]          clr_col_q;
	logic                   clr_wr_s1;

	// Output register.
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      read_char_q;
	logic [COL_FIELD_W-1:0] cursor_col_q;
	logic [ROW_FIELD_W-1:0] cursor_row_q;
	logic                   scrolled_q;

	// Shared address unit operands and result.
	logic [RW-1:0]          au_vrow;
	logic [CW-1:0]          au_col;
	logic [AW-1:0]          au_addr;

	// Cell RAM port.
	logic [AW-1:0]          ram_addr;
	logic                   ram_we;
	logic [CHAR_W-1:0]      ram_wdata;
	logic [CHAR_W-1:0]      ram_rdata;

	// Next cursor position for a put transaction.
	logic [CW:0]            nxt_col;
	logic [RW:0]            nxt_row;
	logic                   nxt_scroll;

	logic                   in_accept;
	logic                   rd_in_range;
	logic                   put_special;
	logic                   out_load;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_accept   = in_valid && in_ready;
	// A read outside the visible screen answers zero without touching the RAM.
	assign rd_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
	assign put_special = (char_code == CH_NEWLINE) || (char_code == CH_BACKSPACE);
	// The finished result moves into the output register once that register is free or is
	// being emptied in the same cycle.
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// The address unit serves three users: cell reads, character stores and row blanking.
	// Blanking uses visible row 0, which is the physical row that scrolls off the top.
	always_comb begin
		case (state_q)
			ST_CLEAR: begin
				au_vrow = '0;
				au_col  = clr_col_q;
			end
			ST_WADDR: begin
				au_vrow = cur_row_q;
				au_col  = cur_col_q;
			end
			default: begin
				au_vrow = RW'(rrow_q);
				au_col  = CW'(rcol_q);
			end
		endcase
	end

	ttcw_addr_unit #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_addr_unit (
		.clk     (clk),
		.top_row (top_q),
		.vrow    (au_vrow),
		.col     (au_col),
		.addr    (au_addr)
	);

	// The reset sweep drives the RAM address directly; everything else goes through the unit.
	// The blanking write strobe is delayed in clr_wr_s1 to match the unit's register.
	always_comb begin
		ram_addr  = au_addr;
		ram_we    = clr_wr_s1 || (state_q == ST_WMEM);
		ram_wdata = (state_q == ST_WMEM) ? char_q : CH_SPACE;
		if (state_q == ST_INIT) begin
			ram_addr  = init_cnt_q;
			ram_we    = 1'b1;
			ram_wdata = CH_SPACE;
		end
	end

	ttcw_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (CELL_COUNT)
	) u_cell_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Cursor motion: newline, backspace or advance, then column wrap, then scroll on row overflow.
	always_comb begin
		nxt_col = {1'b0, cur_col_q};
		nxt_row = {1'b0, cur_row_q};
		if (char_q == CH_NEWLINE) begin
			nxt_col = '0;
			nxt_row = nxt_row + (RW+1)'(1);
		end else if (char_q == CH_BACKSPACE) begin
			if (nxt_col != '0) begin
				nxt_col = nxt_col - (CW+1)'(1);
			end
		end else begin
			nxt_col = nxt_col + (CW+1)'(1);
		end
		if (32'(nxt_col) >= COLUMNS) begin
			nxt_col = '0;
			nxt_row = nxt_row + (RW+1)'(1);
		end
		nxt_scroll = (32'(nxt_row) >= ROWS);
		if (nxt_scroll) begin
			nxt_row = (RW+1)'(ROWS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_cnt_q  <= '0;
			top_q       <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			clr_wr_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + AW'(1);
					if (init_cnt_q == AW'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						mode_q   <= mode;
						char_q   <= char_code;
						rrow_q   <= read_row;
						rcol_q   <= read_col;
						rchar_q  <= '0;
						scroll_q <= 1'b0;
						if (mode == MODE_READ) begin
							state_q <= rd_in_range ? ST_RADDR : ST_DONE;
						end else begin
							state_q <= put_special ? ST_CURSOR : ST_WADDR;
						end
					end
				end
				ST_RADDR: begin
					state_q <= ST_RMEM;
				end
				ST_RMEM: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					rchar_q <= ram_rdata;
					state_q <= ST_DONE;
				end
				ST_WADDR: begin
					state_q <= ST_WMEM;
				end
				ST_WMEM: begin
					state_q <= ST_CURSOR;
				end
				ST_CURSOR: begin
					cur_col_q <= nxt_col[CW-1:0];
					cur_row_q <= nxt_row[RW-1:0];
					scroll_q  <= nxt_scroll;
					clr_col_q <= '0;
					state_q   <= nxt_scroll ? ST_CLEAR : ST_DONE;
				end
				ST_CLEAR: begin
					clr_wr_s1 <= 1'b1;
					clr_col_q <= clr_col_q + CW'(1);
					if (clr_col_q == CW'(COLUMNS - 1)) begin
						state_q <= ST_CLRTAIL;
					end
				end
				ST_CLRTAIL: begin
					// The last blank lands this cycle; only now may the top pointer move.
					clr_wr_s1 <= 1'b0;
					top_q     <= (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						read_char_q  <= (mode_q == MODE_READ) ? rchar_q : '0;
						cursor_col_q <= COL_FIELD_W'(cur_col_q);
						cursor_row_q <= ROW_FIELD_W'(cur_row_q);
						scrolled_q   <= scroll_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_char  = read_char_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign scrolled   = scrolled_q;

endmodule

>>> dv/terminal_screen_checker.sv
`timescale 1ns / 1ps

module terminal_screen_checker
	import ttcw_pkg::*;
#(
	parameter int unsigned COLUMNS = 80,
	parameter int unsigned ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   mode,
	input  logic [CHAR_W-1:0]      char_code,
	input  logic [ROW_FIELD_W-1:0] read_row,
	input  logic [COL_FIELD_W-1:0] read_col,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [CHAR_W-1:0]      read_char,
	input  logic [COL_FIELD_W-1:0] cursor_col,
	input  logic [ROW_FIELD_W-1:0] cursor_row,
	input  logic                   scrolled,
	output int unsigned            mismatches,
	output int unsigned            replies_waiting
);

	localparam int unsigned CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [CHAR_W-1:0]      read_char;
		logic [COL_FIELD_W-1:0] cursor_col;
		logic [ROW_FIELD_W-1:0] cursor_row;
		logic                   scrolled;
	} screen_reply_t;

	// Shadow of the screen: physical cells, rotating top line and cursor.
	logic [CHAR_W-1:0] shadow_cells [CELLS];
	int unsigned       top_line;
	int unsigned       cur_x;
	int unsigned       cur_y;
	int unsigned       replies_seen;
	screen_reply_t     replies_due [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] result %0d: %s", $realtime, replies_seen, msg);
		mismatches++;
	endtask

	// Applies one transaction to the shadow screen and returns the reply it should produce.
	task automatic predict_screen(
		input  logic                   m,
		input  logic [CHAR_W-1:0]      ch,
		input  logic [ROW_FIELD_W-1:0] r,
		input  logic [COL_FIELD_W-1:0] c,
		output screen_reply_t          reply
	);
		int unsigned line_base;
		reply = '0;
		if (m == MODE_READ) begin
			if (r < ROWS && c < COLUMNS)
				reply.read_char = shadow_cells[((top_line + r) % ROWS) * COLUMNS + c];
		end else begin
			if (ch == CH_NEWLINE) begin
				cur_x = 0;
				cur_y++;
			end else if (ch == CH_BACKSPACE) begin
				if (cur_x > 0)
					cur_x--;
			end else begin
				shadow_cells[((top_line + cur_y) % ROWS) * COLUMNS + cur_x] = ch;
				cur_x++;
			end
			if (cur_x >= COLUMNS) begin
				cur_x = 0;
				cur_y++;
			end
			if (cur_y >= ROWS) begin
				// The old top line turns into the blank bottom line.
				line_base = top_line * COLUMNS;
				for (int unsigned k = 0; k < COLUMNS; k++)
					shadow_cells[line_base + k] = CH_SPACE;
				top_line = (top_line + 1) % ROWS;
				cur_y = ROWS - 1;
				reply.scrolled = 1'b1;
			end
		end
		reply.cursor_col = cur_x[COL_FIELD_W-1:0];
		reply.cursor_row = cur_y[ROW_FIELD_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		screen_reply_t want;
		screen_reply_t got;
		if (!arst_n) begin
			for (int unsigned i = 0; i < CELLS; i++)
				shadow_cells[i] = CH_SPACE;
			top_line = 0;
			cur_x = 0;
			cur_y = 0;
			replies_seen = 0;
			replies_due.delete();
			replies_waiting <= 0;
		end else begin
			// A result can never belong to an item accepted at the same edge, so it is
			// checked before that item is predicted.
			if (out_valid && out_ready) begin
				got = '{read_char, cursor_col, cursor_row, scrolled};
				if (replies_due.size() == 0) begin
					report_mismatch("result arrived with no transaction pending");
				end else begin
					want = replies_due.pop_front();
					if (got.read_char !== want.read_char)
						report_mismatch($sformatf("read_char got %0h expected %0h",
							got.read_char, want.read_char));
					if (got.cursor_col !== want.cursor_col)
						report_mismatch($sformatf("cursor_col got %0d expected %0d",
							got.cursor_col, want.cursor_col));
					if (got.cursor_row !== want.cursor_row)
						report_mismatch($sformatf("cursor_row got %0d expected %0d",
							got.cursor_row, want.cursor_row));
					if (got.scrolled !== want.scrolled)
						report_mismatch($sformatf("scrolled got %0b expected %0b",
							got.scrolled, want.scrolled));
				end
				replies_seen++;
			end
			if (in_valid && in_ready) begin
				predict_screen(mode, char_code, read_row, read_col, want);
				replies_due.push_back(want);
			end
			replies_waiting <= replies_due.size();
		end
	end

endmodule

>>> dv/text_terminal_cell_writer_tb.sv
`timescale 1ns / 1ps

module text_terminal_cell_writer_tb;
	import ttcw_pkg::*;

	localparam int unsigned COLUMNS = 80;
	localparam int unsigned ROWS    = 25;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   mode = MODE_PUT;
	logic [CHAR_W-1:0]      char_code = '0;
	logic [ROW_FIELD_W-1:0] read_row = '0;
	logic [COL_FIELD_W-1:0] read_col = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CHAR_W-1:0]      read_char;
	logic [COL_FIELD_W-1:0] cursor_col;
	logic [ROW_FIELD_W-1:0] cursor_row;
	logic                   scrolled;

	int unsigned mismatches;
	int unsigned replies_waiting;

	// Idle rates in percent. The sender rate is only used by the stimulus process; the
	// receiver rate is handed over with nonblocking writes.
	int unsigned tx_idle_pct = 25;
	int unsigned rx_idle_pct = 80;
	int unsigned items_sent = 0;

	// One long receiver stall, requested by the stimulus and counted by the receiver.
	logic        stall_request = 1'b0;
	logic        stall_done;
	int unsigned stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_terminal_cell_writer #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_char (read_char),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.scrolled  (scrolled)
	);

	terminal_screen_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.char_code      (char_code),
		.read_row       (read_row),
		.read_col       (read_col),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_char      (read_char),
		.cursor_col     (cursor_col),
		.cursor_row     (cursor_row),
		.scrolled       (scrolled),
		.mismatches     (mismatches),
		.replies_waiting(replies_waiting)
	);

	// Receiver side. Normally out_ready is random at the current idle rate. Once the
	// stimulus asks for it, the receiver holds off until its stall counter runs out; the block's
	// output register and its one transaction in flight fill up and in_ready has to drop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_request && !stall_done) begin
			out_ready <= 1'b0;
			stall_left <= 299;
			stall_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offers one transaction and returns at the edge where it is accepted. A random gap may
	// come first; without a gap valid simply stays high into the next transaction.
	task automatic send_item(
		input logic                   m,
		input logic [CHAR_W-1:0]      ch,
		input logic [ROW_FIELD_W-1:0] r,
		input logic [COL_FIELD_W-1:0] c
	);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		char_code <= ch;
		read_row <= r;
		read_col <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Put and read transactions carry random values in the fields they do not use, so
	// the block has to ignore them.
	task automatic put_char(input logic [CHAR_W-1:0] ch);
		send_item(MODE_PUT, ch, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
	endtask

	task automatic read_cell(input int unsigned r, input int unsigned c);
		send_item(MODE_READ, CHAR_W'($urandom), r[ROW_FIELD_W-1:0], c[COL_FIELD_W-1:0]);
	endtask

	// Mostly printable text, now and then any byte at all, which also lets a stray
	// newline or backspace turn up inside a run of text.
	function automatic logic [CHAR_W-1:0] pick_text_char();
		if ($urandom_range(9) == 0)
			return CHAR_W'($urandom_range(255));
		return CHAR_W'($urandom_range(126, 32));
	endfunction

	// Holds the sender back until the block has answered everything it accepted.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_waiting != 0)
			@(posedge clk);
	endtask

	// One burst of terminal traffic. Runs of text are the bulk; a long run is sure to
	// pass the last column, and once the screen has scrolled the cursor lives on the last
	// row, so those runs also wrap on the last row. Reads look at the visible screen, and
	// a few point outside it to exercise the high bits of both read fields.
	task automatic random_burst();
		int unsigned kind;
		int unsigned count;
		kind = $urandom_range(99);
		if (kind < 45) begin
			count = ($urandom_range(9) == 0) ? $urandom_range(100, 80) : $urandom_range(12, 1);
			repeat (count)
				put_char(pick_text_char());
		end else if (kind < 57) begin
			repeat ($urandom_range(3, 1))
				put_char(CH_NEWLINE);
		end else if (kind < 66) begin
			repeat ($urandom_range(4, 1))
				put_char(CH_BACKSPACE);
		end else if (kind < 92) begin
			repeat ($urandom_range(4, 1))
				read_cell($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
		end else if ($urandom_range(1) == 0) begin
			read_cell($urandom_range(31, ROWS), $urandom_range(127));
		end else begin
			read_cell($urandom_range(31), $urandom_range(127, COLUMNS));
		end
	endtask

	initial begin : stimulus
		int unsigned wait_cycles;

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles a quarter of the time, receiver most of the time.
		// The first transactions wait out the block's clearing pass on their own.

		// A freshly cleared screen reads spaces at its corners; cells off the screen
		// read as zero.
		read_cell(0, 0);
		read_cell(ROWS - 1, COLUMNS - 1);
		read_cell(ROWS, 0);
		read_cell(0, COLUMNS);
		read_cell(31, 127);
		// Backspace at column 0 goes nowhere.
		put_char(CH_BACKSPACE);
		// The byte extremes are ordinary characters.
		put_char(8'h00);
		put_char(8'hFF);
		put_char(8'h41);
		// Backspace steps back without erasing, and the next byte overwrites.
		put_char(CH_BACKSPACE);
		read_cell(0, 2);
		put_char(8'h42);
		read_cell(0, 2);
		// Newlines down to the last row; the final one scrolls and leaves the cursor at
		// the start of the last row.
		repeat (ROWS)
			put_char(CH_NEWLINE);
		read_cell(ROWS - 1, 0);

		while (items_sent < 190)
			random_burst();

		// Phase two: the other way round. It ends with the sender pausing until every
		// result is in.
		tx_idle_pct = 80;
		rx_idle_pct <= 25;
		while (items_sent < 360)
			random_burst();
		drain_results();

		// Phase three: nobody idles, except for one long receiver stall at its start
		// while the sender keeps offering transactions back to back.
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		stall_request <= 1'b1;
		while (items_sent < 530)
			random_burst();

		in_valid <= 1'b0;
		wait_cycles = 0;
		@(posedge clk);
		while (replies_waiting != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20)
			@(posedge clk);

		if (replies_waiting != 0)
			$display("%0d expected results never arrived", replies_waiting);
		if (mismatches == 0 && replies_waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, clearing pass included.
	initial begin
		#5_000_000;
		$display("timeout after %0d transactions", items_sent);
		$display("TEST FAILED");
		$finish;
	end

endmodule
